>>> sv/kcs_pkg.sv
package kcs_pkg;

  // Default table depth.
  localparam int DEFAULT_MAX_KEYS = 64;

  // Action codes carried in the input word.
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_EVAL   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Width of the interpolation dividend, one quotient bit per step.
  localparam int DVD_W     = 65;
  localparam int DIV_STEPS = DVD_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       clear;
    logic       idx_zero;
    logic       idx_one;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_from_count;
    logic       pos_from_idx;
    logic       pos_from_count;
    logic       rd_idx;
    logic       rd_idx_m1;
    logic       wr_shift;
    logic       wr_new;
    logic       lat_prev;
    logic       lat_next;
    logic       hold_out;
    logic       sel_b;
    logic       prep;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       fin;
    logic       set_status;
    logic [1:0] status_code;
    logic       emit;
  } kcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] act;
    logic       count_zero;
    logic       full;
    logic       append;
    logic       kt_eq;
    logic       kt_lt;
    logic       idx_lt_count;
    logic       idx_eq_pos;
    logic       hold_mode;
    logic       vector;
    logic       sel_b;
    logic       div_last;
    logic       out_free;
  } kcs_stat_t;

endpackage

>>> sv/keyframe_curve_sampler.sv
// Keyframe curve sampler.
// Input stream (s_tvalid/s_tready/s_tdata) carries one word per action:
// clear the table, insert a keyframe, or evaluate the curve at a time.
// Every accepted word yields exactly one output word on m_tvalid/m_tready/
// m_tdata with a status, the evaluated components, the key count and the
// first and last key times.
// Keys live in a sorted store of MAX_KEYS entries with one read and one
// write port. An insert compares keys in order and then moves each later key
// up by one entry; evaluate in hold mode, with a single key or past the last
// key returns the values of the key found; linear interpolation runs the
// 65-step serial divider once per component, so once for a scalar curve and
// twice for a two-component curve.
// s_tready is high only while no word is in work.
// A finished word sits in the output register; a new word can be taken
// while it waits, and that word's result waits until the register frees.
// Reset (synchronous, rst) empties the table, sets linear mode and a scalar
// curve. Registers via APB: 0x0 interp_mode, 0x4 component_count; a write
// that switches between scalar and vector empties the table.
module keyframe_curve_sampler
  import kcs_pkg::*;
#(
  parameter int MAX_KEYS = DEFAULT_MAX_KEYS,
  parameter int CW       = $clog2(MAX_KEYS + 1),
  parameter int OUT_BITS = 2 + 32 + 32 + CW + 32 + 32 + 1,
  parameter int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // action[1:0], key_time[33:2], value_a[65:34], value_b[97:66], zero fill
  input  logic [103:0]     s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status, out_a, out_b, key_total, first_time, last_time, curve_valid
  output logic [OUT_W-1:0] m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  kcs_cmd_t      cmd;
  kcs_stat_t     stat;
  logic          interp_mode;
  logic [1:0]    component_count;
  logic          cfg_we;
  logic          cfg_clear;
  logic [1:0]    o_status;
  logic [31:0]   o_a;
  logic [31:0]   o_b;
  logic [CW-1:0] o_total;
  logic [31:0]   o_first;
  logic [31:0]   o_last;
  logic          o_cv;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign cfg_clear = cfg_we && (paddr[2] == REG_COUNT) &&
                     (component_count[1] != pwdata[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode     <= 1'b1;
      component_count <= 2'd1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_MODE) begin
        interp_mode <= pwdata[0];
      end else begin
        component_count <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = {31'b0, interp_mode};
      default:  prdata = {30'b0, component_count};
    endcase
  end

  kcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kcs_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .CW       (CW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (s_tdata[1:0]),
    .in_key_time     (s_tdata[33:2]),
    .in_value_a      (s_tdata[65:34]),
    .in_value_b      (s_tdata[97:66]),
    .mode_linear     (interp_mode),
    .vector          (component_count[1]),
    .cfg_clear       (cfg_clear),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (o_status),
    .out_a           (o_a),
    .out_b           (o_b),
    .out_key_total   (o_total),
    .out_first_time  (o_first),
    .out_last_time   (o_last),
    .out_curve_valid (o_cv)
  );

  // Output word packing, first field in the lowest bits.
  assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, o_cv, o_last, o_first, o_total,
                    o_b, o_a, o_status};

endmodule

>>> sv/kcs_ctrl.sv
module kcs_ctrl
  import kcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kcs_stat_t stat,
  output kcs_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_DECODE    = 5'd1;
  localparam logic [4:0] S_ISCAN_RD  = 5'd2;
  localparam logic [4:0] S_ISCAN_CMP = 5'd3;
  localparam logic [4:0] S_SHIFT_CHK = 5'd4;
  localparam logic [4:0] S_SHIFT_WR  = 5'd5;
  localparam logic [4:0] S_ESCAN_CHK = 5'd6;
  localparam logic [4:0] S_ESCAN_CMP = 5'd7;
  localparam logic [4:0] S_EPREV     = 5'd8;
  localparam logic [4:0] S_ENEXT     = 5'd9;
  localparam logic [4:0] S_ELOAD     = 5'd10;
  localparam logic [4:0] S_PREP      = 5'd11;
  localparam logic [4:0] S_MUL       = 5'd12;
  localparam logic [4:0] S_DIVI      = 5'd13;
  localparam logic [4:0] S_DIV       = 5'd14;
  localparam logic [4:0] S_FIN       = 5'd15;
  localparam logic [4:0] S_DONE      = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one word through search, shift and interpolation.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          ACT_INSERT: begin
            if (stat.append) begin
              if (stat.full) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FULL;
                state_next      = S_DONE;
              end else begin
                cmd.idx_from_count = 1'b1;
                cmd.pos_from_count = 1'b1;
                state_next         = S_SHIFT_CHK;
              end
            end else begin
              cmd.idx_zero = 1'b1;
              state_next   = S_ISCAN_RD;
            end
          end
          ACT_EVAL: begin
            if (stat.count_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              cmd.idx_one = 1'b1;
              state_next  = S_ESCAN_CHK;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_ISCAN_RD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_ISCAN_CMP;
      end
      S_ISCAN_CMP: begin
        if (stat.kt_eq) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_DUP;
          state_next      = S_DONE;
        end else if (stat.kt_lt) begin
          if (stat.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FULL;
            state_next      = S_DONE;
          end else begin
            cmd.pos_from_idx   = 1'b1;
            cmd.idx_from_count = 1'b1;
            state_next         = S_SHIFT_CHK;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ISCAN_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (stat.idx_eq_pos) begin
          cmd.wr_new = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_idx_m1 = 1'b1;
          state_next    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = S_SHIFT_CHK;
      end
      S_ESCAN_CHK: begin
        if (stat.idx_lt_count) begin
          cmd.rd_idx = 1'b1;
          state_next = S_ESCAN_CMP;
        end else begin
          state_next = S_EPREV;
        end
      end
      S_ESCAN_CMP: begin
        if (stat.kt_lt) begin
          state_next = S_EPREV;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ESCAN_CHK;
        end
      end
      S_EPREV: begin
        cmd.rd_idx_m1 = 1'b1;
        state_next    = S_ENEXT;
      end
      S_ENEXT: begin
        cmd.lat_prev = 1'b1;
        if (!stat.idx_lt_count || stat.hold_mode) begin
          cmd.hold_out = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_ELOAD;
        end
      end
      S_ELOAD: begin
        cmd.lat_next = 1'b1;
        state_next   = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (stat.vector && !stat.sel_b) begin
          cmd.sel_b  = 1'b1;
          state_next = S_PREP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/kcs_datapath.sv
module kcs_datapath
  import kcs_pkg::*;
#(
  parameter int MAX_KEYS = DEFAULT_MAX_KEYS,
  parameter int CW       = $clog2(MAX_KEYS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  kcs_cmd_t           cmd,
  output kcs_stat_t          stat,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_key_time,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic               mode_linear,
  input  logic               vector,
  input  logic               cfg_clear,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_a,
  output logic [31:0]        out_b,
  output logic [CW-1:0]      out_key_total,
  output logic [31:0]        out_first_time,
  output logic [31:0]        out_last_time,
  output logic               out_curve_valid
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_KEYS);
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  // Latched input word.
  logic [1:0]         act;
  logic signed [31:0] kt;
  logic signed [31:0] va;
  logic signed [31:0] vb;

  // Table bookkeeping.
  logic [CW-1:0]      count;
  logic signed [31:0] earliest;
  logic signed [31:0] latest;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      idx_m1;

  // Key store.
  logic signed [31:0] t_mem [MAX_KEYS];
  logic [31:0]        a_mem [MAX_KEYS];
  logic [31:0]        b_mem [MAX_KEYS];
  logic signed [31:0] rd_t;
  logic [31:0]        rd_a;
  logic [31:0]        rd_b;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      wa;
  logic               mem_we;

  // Interpolation operands and arithmetic.
  logic signed [31:0] pt;
  logic [31:0]        pa;
  logic [31:0]        pb;
  logic signed [31:0] nt;
  logic [31:0]        na;
  logic [31:0]        nb;
  logic               sel_b;
  logic [31:0]        mv;
  logic [31:0]        mq;
  logic [31:0]        den;
  logic               neg;
  logic [63:0]        prod;
  logic [DVD_W-1:0]   dvd;
  logic [31:0]        rem;
  logic [6:0]         dcnt;

  // Result being built.
  logic [1:0]         res_status;
  logic [31:0]        res_a;
  logic [31:0]        res_b;

  logic [31:0]        v1;
  logic [31:0]        v2;
  logic signed [32:0] dv;
  logic signed [32:0] dq;
  logic signed [32:0] dn;
  logic [32:0]        shifted;
  logic               qbit;
  logic               big;
  logic signed [34:0] sum;
  logic [31:0]        lerp;

  assign idx_m1 = idx - 1'b1;
  assign ra     = cmd.rd_idx_m1 ? idx_m1[AW-1:0] : idx[AW-1:0];
  assign wa     = cmd.wr_new ? pos[AW-1:0] : idx[AW-1:0];
  assign mem_we = cmd.wr_new || cmd.wr_shift;

  // Status toward the controller.
  always_comb begin
    stat              = '0;
    stat.act          = act;
    stat.count_zero   = (count == '0);
    stat.full         = (count == MAXC);
    stat.append       = (count == '0) || (kt > latest);
    stat.kt_eq        = (kt == rd_t);
    stat.kt_lt        = (kt < rd_t);
    stat.idx_lt_count = (idx < count);
    stat.idx_eq_pos   = (idx == pos);
    stat.hold_mode    = !mode_linear;
    stat.vector       = vector;
    stat.sel_b        = sel_b;
    stat.div_last     = (dcnt == 7'd1);
    stat.out_free     = !out_valid || out_ready;
  end

  // Key store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      t_mem[wa] <= cmd.wr_new ? kt : rd_t;
      a_mem[wa] <= cmd.wr_new ? va : rd_a;
      b_mem[wa] <= cmd.wr_new ? vb : rd_b;
    end
    if (cmd.rd_idx || cmd.rd_idx_m1) begin
      rd_t <= t_mem[ra];
      rd_a <= a_mem[ra];
      rd_b <= b_mem[ra];
    end
  end

  // Count and time bounds.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      earliest <= T_MAX;
      latest   <= T_MIN;
    end else if (cmd.clear || cfg_clear) begin
      count    <= '0;
      earliest <= T_MAX;
      latest   <= T_MIN;
    end else if (cmd.wr_new) begin
      count <= count + 1'b1;
      if (kt < earliest) begin
        earliest <= kt;
      end
      if (kt > latest) begin
        latest <= kt;
      end
    end
  end

  // Input latch and scan pointers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      kt  <= in_key_time;
      va  <= in_value_a;
      vb  <= in_value_b;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_one) begin
      idx <= CW'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end else if (cmd.idx_from_count) begin
      idx <= count;
    end
    if (cmd.pos_from_idx) begin
      pos <= idx;
    end else if (cmd.pos_from_count) begin
      pos <= count;
    end
  end

  // Operand setup for the selected component.
  assign v1 = sel_b ? pb : pa;
  assign v2 = sel_b ? nb : na;
  assign dv = $signed({v2[31], v2}) - $signed({v1[31], v1});
  assign dq = $signed({kt[31], kt}) - $signed({pt[31], pt});
  assign dn = $signed({nt[31], nt}) - $signed({pt[31], pt});

  // One restoring division step.
  assign shifted = {rem, dvd[DVD_W-1]};
  assign qbit    = (shifted >= {1'b0, den});

  // Final add with saturation.
  assign big = (dvd[DVD_W-1:34] != '0) || (dvd[33] && (dvd[32:0] != '0));
  assign sum = neg ? ($signed({{3{v1[31]}}, v1}) - $signed({1'b0, dvd[33:0]}))
                   : ($signed({{3{v1[31]}}, v1}) + $signed({1'b0, dvd[33:0]}));
  always_comb begin
    if (big) begin
      lerp = neg ? T_MIN : T_MAX;
    end else if (sum > 35'sd2147483647) begin
      lerp = T_MAX;
    end else if (sum < -35'sd2147483648) begin
      lerp = T_MIN;
    end else begin
      lerp = sum[31:0];
    end
  end

  // Interpolation: operands, multiply, serial divide, add.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel_b <= 1'b0;
    end else if (cmd.sel_b) begin
      sel_b <= 1'b1;
    end
    if (cmd.lat_prev) begin
      pt <= rd_t;
      pa <= rd_a;
      pb <= rd_b;
    end
    if (cmd.lat_next) begin
      nt <= rd_t;
      na <= rd_a;
      nb <= rd_b;
    end
    if (cmd.prep) begin
      mv  <= dv[32] ? 32'(-dv) : dv[31:0];
      mq  <= dq[32] ? 32'(-dq) : dq[31:0];
      den <= dn[31:0];
      neg <= dv[32] ^ dq[32];
    end
    if (cmd.mul) begin
      prod <= mv * mq;
    end
    if (cmd.div_init) begin
      dvd  <= {1'b0, prod} + {{(DVD_W - 31){1'b0}}, den[31:1]};
      rem  <= '0;
      dcnt <= 7'(DIV_STEPS);
    end else if (cmd.div_step) begin
      rem  <= qbit ? 32'(shifted - {1'b0, den}) : shifted[31:0];
      dvd  <= {dvd[DVD_W-2:0], qbit};
      dcnt <= dcnt - 1'b1;
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= ST_OK;
      res_a      <= '0;
      res_b      <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.hold_out) begin
        res_a <= rd_a;
        res_b <= vector ? rd_b : '0;
      end
      if (cmd.fin) begin
        if (sel_b) begin
          res_b <= lerp;
        end else begin
          res_a <= lerp;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status      <= res_status;
      out_a           <= res_a;
      out_b           <= res_b;
      out_key_total   <= count;
      out_first_time  <= earliest;
      out_last_time   <= latest;
      out_curve_valid <= !mode_linear || (count > CW'(1));
    end
  end

  // The table never holds more keys than it has room for.
  assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("key count above table depth");

  // An empty table shows the empty bounds.
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (earliest == T_MAX && latest == T_MIN))
    else $error("empty table with stale time bounds");

  // A stored table keeps its first key no later than its last.
  assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (earliest <= latest))
    else $error("time bounds out of order");

  // A write into the store only happens below the table depth.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (count < MAXC))
    else $error("store written while table full");

endmodule
